// ===== src/jsu_pkg.sv =====
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types and constants for the JSON string unescaper: the input and
// result beat formats, the job record between the front and back ends, and
// the decoder's character codes.
// ----------------------------------------------------------------------------
package jsu_pkg;

  typedef struct packed {
    logic [7:0] in_char;
    logic       in_last;
  } in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       run_end;
    logic       string_end;
  } out_t;

  localparam int unsigned MaxBytes   = 5;
  localparam int unsigned ByteIdxW   = $clog2(MaxBytes);
  localparam int unsigned CountW     = $clog2(MaxBytes + 1);
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);
  localparam int unsigned QCountW    = $clog2(QueueDepth + 1);

  // One input byte's worth of output bytes.
  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [CountW-1:0]        count;
    logic                     last;
  } job_t;

  // Decoder modes.
  localparam logic [1:0] MODE_NORMAL = 2'd0;
  localparam logic [1:0] MODE_ESCAPE = 2'd1;
  localparam logic [1:0] MODE_HEX    = 2'd2;

  // Character codes.
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_N         = 8'h6E;
  localparam logic [7:0] CH_T         = 8'h74;
  localparam logic [7:0] CH_R         = 8'h72;
  localparam logic [7:0] CH_B         = 8'h62;
  localparam logic [7:0] CH_F         = 8'h66;
  localparam logic [7:0] CH_U         = 8'h75;
  localparam logic [7:0] CH_LF        = 8'h0A;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [7:0] CH_BS        = 8'h08;
  localparam logic [7:0] CH_FF        = 8'h0C;

  // UTF-8 encoding constants.
  localparam logic [7:0]  UTF8_LEAD2 = 8'hC0;
  localparam logic [7:0]  UTF8_LEAD3 = 8'hE0;
  localparam logic [7:0]  UTF8_CONT  = 8'h80;
  localparam logic [15:0] UTF8_ONE_LIMIT = 16'h0080;
  localparam logic [15:0] UTF8_TWO_LIMIT = 16'h0800;

  // Bit 4 set means the byte is not a hex digit; bits 3:0 hold the value.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b0, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b0, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b0, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage

// ===== src/jsu_front.sv =====
// ----------------------------------------------------------------------------
// jsu_front
// Decoder front end: accepts one input byte per beat, tracks escape and hex
// state, and builds the list of output bytes that the byte causes.
// ----------------------------------------------------------------------------
module jsu_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          item_valid,
  output logic          item_ready,
  input  jsu_pkg::in_t  item,
  input  logic          q_ready,
  output logic          push,
  output jsu_pkg::job_t job
);

  logic [1:0] mode;
  logic [1:0] mode_next;
  logic [1:0] hex_count;
  logic [1:0] hex_count_next;
  logic [7:0] hex_chars [3];
  logic       hex_wr;
  logic       accept;

  logic [7:0]  c;
  logic        last;
  logic [4:0]  hv;
  logic [4:0]  h0;
  logic [4:0]  h1;
  logic [4:0]  h2;
  logic [15:0] cp;
  logic [jsu_pkg::CountW-1:0] n;

  assign c          = item.in_char;
  assign last       = item.in_last;
  assign hv         = jsu_pkg::hex_digit(c);
  assign h0         = jsu_pkg::hex_digit(hex_chars[0]);
  assign h1         = jsu_pkg::hex_digit(hex_chars[1]);
  assign h2         = jsu_pkg::hex_digit(hex_chars[2]);
  assign item_ready = q_ready;
  assign accept     = item_valid && q_ready;
  assign push       = accept && (n != '0);

  assign cp = {h0[3:0], h1[3:0], h2[3:0], hv[3:0]};

  always_comb begin
    job            = '0;
    n              = '0;
    mode_next      = mode;
    hex_count_next = hex_count;
    hex_wr         = 1'b0;
    unique case (mode)
      jsu_pkg::MODE_ESCAPE: begin
        mode_next = jsu_pkg::MODE_NORMAL;
        case (c)
          jsu_pkg::CH_N: begin job.bytes[n] = jsu_pkg::CH_LF;  n = n + 1'b1; end
          jsu_pkg::CH_T: begin job.bytes[n] = jsu_pkg::CH_TAB; n = n + 1'b1; end
          jsu_pkg::CH_R: begin job.bytes[n] = jsu_pkg::CH_CR;  n = n + 1'b1; end
          jsu_pkg::CH_B: begin job.bytes[n] = jsu_pkg::CH_BS;  n = n + 1'b1; end
          jsu_pkg::CH_F: begin job.bytes[n] = jsu_pkg::CH_FF;  n = n + 1'b1; end
          jsu_pkg::CH_U: begin
            if (last) begin
              job.bytes[n] = jsu_pkg::CH_U;
              n = n + 1'b1;
            end else begin
              mode_next      = jsu_pkg::MODE_HEX;
              hex_count_next = 2'd0;
            end
          end
          default: begin job.bytes[n] = c; n = n + 1'b1; end
        endcase
      end
      jsu_pkg::MODE_HEX: begin
        if (!hv[4] && hex_count == 2'd3) begin
          mode_next      = jsu_pkg::MODE_NORMAL;
          hex_count_next = 2'd0;
          if (cp < jsu_pkg::UTF8_ONE_LIMIT) begin
            job.bytes[n] = cp[7:0];
            n = n + 1'b1;
          end else if (cp < jsu_pkg::UTF8_TWO_LIMIT) begin
            job.bytes[n] = jsu_pkg::UTF8_LEAD2 | {3'b000, cp[10:6]};
            n = n + 1'b1;
            job.bytes[n] = jsu_pkg::UTF8_CONT | {2'b00, cp[5:0]};
            n = n + 1'b1;
          end else begin
            job.bytes[n] = jsu_pkg::UTF8_LEAD3 | {4'b0000, cp[15:12]};
            n = n + 1'b1;
            job.bytes[n] = jsu_pkg::UTF8_CONT | {2'b00, cp[11:6]};
            n = n + 1'b1;
            job.bytes[n] = jsu_pkg::UTF8_CONT | {2'b00, cp[5:0]};
            n = n + 1'b1;
          end
        end else if (!hv[4] && !last) begin
          hex_wr         = 1'b1;
          hex_count_next = hex_count + 2'd1;
        end else begin
          // Broken or cut-off escape: replay the 'u' and the digits so far literally,
          // then treat the current byte as an ordinary one.
          job.bytes[n] = jsu_pkg::CH_U;
          n = n + 1'b1;
          if (hex_count > 2'd0) begin job.bytes[n] = hex_chars[0]; n = n + 1'b1; end
          if (hex_count > 2'd1) begin job.bytes[n] = hex_chars[1]; n = n + 1'b1; end
          if (hex_count > 2'd2) begin job.bytes[n] = hex_chars[2]; n = n + 1'b1; end
          mode_next      = jsu_pkg::MODE_NORMAL;
          hex_count_next = 2'd0;
          if (c == jsu_pkg::CH_BACKSLASH && !last) begin
            mode_next = jsu_pkg::MODE_ESCAPE;
          end else begin
            job.bytes[n] = c;
            n = n + 1'b1;
          end
        end
      end
      default: begin
        mode_next = jsu_pkg::MODE_NORMAL;
        if (c == jsu_pkg::CH_BACKSLASH && !last) begin
          mode_next = jsu_pkg::MODE_ESCAPE;
        end else begin
          job.bytes[n] = c;
          n = n + 1'b1;
        end
      end
    endcase
    if (last) begin
      mode_next      = jsu_pkg::MODE_NORMAL;
      hex_count_next = 2'd0;
    end
    job.count = n;
    job.last  = last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= jsu_pkg::MODE_NORMAL;
      hex_count <= 2'd0;
    end else if (accept) begin
      mode      <= mode_next;
      hex_count <= hex_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && hex_wr) begin
      hex_chars[hex_count] <= c;
    end
  end

endmodule

// ===== src/jsu_queue.sv =====
// ----------------------------------------------------------------------------
// jsu_queue
// Short job queue between the decoder and the output serializer.
// ----------------------------------------------------------------------------
module jsu_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  jsu_pkg::job_t push_job,
  output logic          q_ready,
  input  logic          pop,
  output logic          head_valid,
  output jsu_pkg::job_t head
);

  jsu_pkg::job_t entries [jsu_pkg::QueueDepth];
  logic [jsu_pkg::QPtrW-1:0]   wr_ptr;
  logic [jsu_pkg::QPtrW-1:0]   rd_ptr;
  logic [jsu_pkg::QCountW-1:0] fill;

  assign q_ready    = (fill != jsu_pkg::QCountW'(jsu_pkg::QueueDepth));
  assign head_valid = (fill != '0);
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

endmodule

// ===== src/jsu_back.sv =====
// ----------------------------------------------------------------------------
// jsu_back
// Output serializer: walks the bytes of the job at the queue head and sends
// one result beat per cycle, while result_ready is high, from an output register.
// ----------------------------------------------------------------------------
module jsu_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          head_valid,
  input  jsu_pkg::job_t head,
  output logic          pop,
  output logic          result_valid,
  input  logic          result_ready,
  output jsu_pkg::out_t result
);

  logic [jsu_pkg::ByteIdxW-1:0] idx;
  logic load;
  logic final_byte;

  assign load       = head_valid && (!result_valid || result_ready);
  assign final_byte = (jsu_pkg::CountW'(idx) + 1'b1 == head.count);
  assign pop        = load && final_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      idx          <= '0;
    end else if (load) begin
      result_valid <= 1'b1;
      idx          <= final_byte ? '0 : idx + 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result.out_char   <= head.bytes[idx];
      result.run_end    <= final_byte;
      result.string_end <= final_byte && head.last;
    end
  end

endmodule

// ===== src/json_string_unescape_top.sv =====
// ----------------------------------------------------------------------------
// json_string_unescape_top
// Streaming JSON string-body unescaper with UTF-8 output for \u escapes.
// ----------------------------------------------------------------------------
// One input byte is taken per cycle while the four-entry job queue has room.
// A byte yields zero to five output bytes; the output register sends one
// result beat per cycle while result_ready is high, so a byte that yields
// more than one result holds the output side until all have gone. Sustained
// input rate is one byte per cycle only while each byte yields at most one
// result and result_ready stays high. The accepting edge writes a byte's job
// into the queue; the output register takes its first result from the head.
// A result beat carries run_end on the last byte a given input byte caused
// and string_end on the last result of a string.
module json_string_unescape_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          item_valid,
  output logic          item_ready,
  input  jsu_pkg::in_t  item,
  output logic          result_valid,
  input  logic          result_ready,
  output jsu_pkg::out_t result
);

  logic          q_ready;
  logic          push;
  jsu_pkg::job_t push_job;
  logic          pop;
  logic          head_valid;
  jsu_pkg::job_t head;

  jsu_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .q_ready    (q_ready),
    .push       (push),
    .job        (push_job)
  );

  jsu_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .q_ready    (q_ready),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  jsu_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

// ===== src/jsu_checker.sv =====
// ----------------------------------------------------------------------------
// jsu_checker
// Port-level checks for the JSON string unescaper, bound to the top level.
// ----------------------------------------------------------------------------
module jsu_checker (
  input logic          clk,
  input logic          rst,
  input logic          item_valid,
  input logic          item_ready,
  input jsu_pkg::in_t  item,
  input logic          result_valid,
  input logic          result_ready,
  input jsu_pkg::out_t result
);

  // A waiting input beat must hold until it is taken.
  assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_ready |=> item_valid && $stable(item))
    else $error("input beat changed while stalled");

  // A stalled result beat must hold.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result beat changed while stalled");

  // Nothing leaves the block right after reset.
  assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  // The end of a string is always the end of a run.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result.string_end |-> result.run_end)
    else $error("string_end without run_end");

  // The rest of a multi-byte run is already queued, so it follows at once.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_ready && !result.run_end |=> result_valid)
    else $error("gap inside a run of results");

endmodule

bind json_string_unescape_top jsu_checker u_jsu_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_ready   (item_ready),
  .item         (item),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the JSON string unescaper. A table of directed
// bytes covers the named escapes, the largest hex escape and broken escapes.
// Random strings follow: raw bytes, escapes with random content, broken ones.
// A behavioral decoder or a typed row predicts each accepted byte's results,
// and each result beat is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;

  logic          clk;
  logic          rst;
  logic          item_valid;
  logic          item_ready;
  jsu_pkg::in_t  item;
  logic          result_valid;
  logic          result_ready;
  jsu_pkg::out_t result;

  json_string_unescape_top dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog for a hung handshake.
  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Decoder model
  // --------------------------------------------------------------------------
  logic [1:0] dec_mode;
  logic [1:0] dec_hex_cnt;
  logic [7:0] dec_hex [3];

  jsu_pkg::out_t unescaped_q[$];
  int            err_count;
  int            burst_left;

  function automatic int hex_val(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
    if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
    if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
    return 16;
  endfunction

  function automatic void put_char(inout logic [4:0][7:0] o, inout int n,
                                   input logic [7:0] c);
    if (n < 5) begin
      o[n] = c;
      n++;
    end
  endfunction

  function automatic void plain_byte(input logic [7:0] c, input bit last,
                                     inout logic [4:0][7:0] o, inout int n);
    if (c == jsu_pkg::CH_BACKSLASH && !last) begin
      dec_mode = jsu_pkg::MODE_ESCAPE;
    end else begin
      put_char(o, n, c);
    end
  endfunction

  // Advances the decoder by one byte and returns the bytes it produces.
  function automatic int unescape_byte(input jsu_pkg::in_t b,
                                       output logic [4:0][7:0] o);
    int n;
    int v;
    logic [15:0] cp;
    logic [1:0] cnt;
    n = 0;
    o = '0;
    case (dec_mode)
      jsu_pkg::MODE_ESCAPE: begin
        dec_mode = jsu_pkg::MODE_NORMAL;
        case (b.in_char)
          jsu_pkg::CH_N: put_char(o, n, jsu_pkg::CH_LF);
          jsu_pkg::CH_T: put_char(o, n, jsu_pkg::CH_TAB);
          jsu_pkg::CH_R: put_char(o, n, jsu_pkg::CH_CR);
          jsu_pkg::CH_B: put_char(o, n, jsu_pkg::CH_BS);
          jsu_pkg::CH_F: put_char(o, n, jsu_pkg::CH_FF);
          jsu_pkg::CH_U: begin
            if (b.in_last) begin
              put_char(o, n, jsu_pkg::CH_U);
            end else begin
              dec_mode = jsu_pkg::MODE_HEX;
              dec_hex_cnt = 2'd0;
            end
          end
          default: put_char(o, n, b.in_char);
        endcase
      end
      jsu_pkg::MODE_HEX: begin
        v = hex_val(b.in_char);
        cnt = dec_hex_cnt;
        if (v < 16 && cnt == 2'd3) begin
          cp = {4'(hex_val(dec_hex[0])), 4'(hex_val(dec_hex[1])),
                4'(hex_val(dec_hex[2])), 4'(v)};
          dec_mode = jsu_pkg::MODE_NORMAL;
          dec_hex_cnt = 2'd0;
          if (cp < jsu_pkg::UTF8_ONE_LIMIT) begin
            put_char(o, n, cp[7:0]);
          end else if (cp < jsu_pkg::UTF8_TWO_LIMIT) begin
            put_char(o, n, jsu_pkg::UTF8_LEAD2 | {3'b0, cp[10:6]});
            put_char(o, n, jsu_pkg::UTF8_CONT | {2'b0, cp[5:0]});
          end else begin
            put_char(o, n, jsu_pkg::UTF8_LEAD3 | {4'b0, cp[15:12]});
            put_char(o, n, jsu_pkg::UTF8_CONT | {2'b0, cp[11:6]});
            put_char(o, n, jsu_pkg::UTF8_CONT | {2'b0, cp[5:0]});
          end
        end else if (v < 16 && !b.in_last) begin
          dec_hex[cnt] = b.in_char;
          dec_hex_cnt = cnt + 2'd1;
        end else begin
          // A broken escape gives back the literal 'u' and the digits so far.
          put_char(o, n, jsu_pkg::CH_U);
          for (int i = 0; i < int'(cnt); i++) put_char(o, n, dec_hex[i]);
          dec_mode = jsu_pkg::MODE_NORMAL;
          dec_hex_cnt = 2'd0;
          plain_byte(b.in_char, b.in_last, o, n);
        end
      end
      default: begin
        dec_mode = jsu_pkg::MODE_NORMAL;
        plain_byte(b.in_char, b.in_last, o, n);
      end
    endcase
    if (b.in_last) begin
      dec_mode = jsu_pkg::MODE_NORMAL;
      dec_hex_cnt = 2'd0;
    end
    return n;
  endfunction

  // --------------------------------------------------------------------------
  // Directed stimulus table; typed_n < 0 means the row uses the model.
  // --------------------------------------------------------------------------
  typedef struct {
    logic [7:0]       c;
    bit               last;
    int               typed_n;
    logic [4:0][7:0]  chars;
  } dir_row_t;

  dir_row_t dir_rows[$];

  function automatic void add_row(input logic [7:0] c, input bit last,
                                  input int typed_n = -1,
                                  input logic [7:0] e0 = 8'h00,
                                  input logic [7:0] e1 = 8'h00,
                                  input logic [7:0] e2 = 8'h00,
                                  input logic [7:0] e3 = 8'h00,
                                  input logic [7:0] e4 = 8'h00);
    dir_row_t r;
    r.c = c;
    r.last = last;
    r.typed_n = typed_n;
    r.chars = {e4, e3, e2, e1, e0};
    dir_rows.insert(dir_rows.size(), r);
  endfunction

  // --------------------------------------------------------------------------
  // Sender
  // --------------------------------------------------------------------------
  // Called at a falling edge; returns at a falling edge after acceptance.
  task automatic send_beat(input logic [7:0] c, input bit last, input int typed_n,
                           input logic [4:0][7:0] typed_chars);
    jsu_pkg::in_t b;
    logic [4:0][7:0] chars;
    int n;
    jsu_pkg::out_t r;
    b.in_char = c;
    b.in_last = last;
    item <= b;
    item_valid <= 1'b1;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    n = unescape_byte(b, chars);
    if (typed_n >= 0) begin
      n = typed_n;
      chars = typed_chars;
    end
    for (int i = 0; i < n; i++) begin
      r.out_char = chars[i];
      r.run_end = (i == n - 1);
      r.string_end = (i == n - 1) && last;
      unescaped_q.insert(unescaped_q.size(), r);
    end
    @(negedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 90)
                                               : $urandom_range(1, 12);
    end
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] v, input bit upper);
    if (v < 4'd10) return 8'h30 + 8'(v);
    return (upper ? 8'h41 : 8'h61) + 8'(v) - 8'd10;
  endfunction

  // Builds one random string body from raw bytes, escapes and broken escapes.
  task automatic make_string(ref logic [7:0] s[$]);
    int segs;
    int kind;
    int digits;
    logic [15:0] cp;
    logic [7:0] simple [9];
    simple = '{jsu_pkg::CH_N, jsu_pkg::CH_T, jsu_pkg::CH_R, jsu_pkg::CH_B,
               jsu_pkg::CH_F, "\"", "/", jsu_pkg::CH_BACKSLASH, "x"};
    s.delete();
    segs = $urandom_range(1, 6);
    for (int k = 0; k < segs; k++) begin
      kind = $urandom_range(0, 9);
      if (kind <= 2) begin
        s.insert(s.size(), 8'($urandom_range(0, 255)));
      end else if (kind <= 4) begin
        s.insert(s.size(), jsu_pkg::CH_BACKSLASH);
        if ($urandom_range(0, 4) == 0) s.insert(s.size(), 8'($urandom_range(0, 255)));
        else s.insert(s.size(), simple[$urandom_range(0, 8)]);
      end else if (kind <= 7) begin
        case ($urandom_range(0, 2))
          0:       cp = 16'($urandom_range(0, 'h7F));
          1:       cp = 16'($urandom_range('h80, 'h7FF));
          default: cp = 16'($urandom_range('h800, 'hFFFF));
        endcase
        s.insert(s.size(), jsu_pkg::CH_BACKSLASH);
        s.insert(s.size(), jsu_pkg::CH_U);
        for (int d = 3; d >= 0; d--) begin
          s.insert(s.size(), hex_char(cp[4*d +: 4], $urandom_range(0, 1)));
        end
      end else if (kind == 8) begin
        s.insert(s.size(), jsu_pkg::CH_BACKSLASH);
        s.insert(s.size(), jsu_pkg::CH_U);
        digits = $urandom_range(0, 3);
        for (int d = 0; d < digits; d++) begin
          s.insert(s.size(), hex_char(4'($urandom), $urandom_range(0, 1)));
        end
        case ($urandom_range(0, 3))
          0:       s.insert(s.size(), "G");
          1:       s.insert(s.size(), jsu_pkg::CH_BACKSLASH);
          2:       s.insert(s.size(), 8'($urandom_range(0, 255)));
          default: ; // string may end here, leaving the escape short
        endcase
      end else begin
        s.insert(s.size(), jsu_pkg::CH_BACKSLASH);
      end
    end
  endtask

  initial begin : stimulus
    logic [7:0] body[$];
    int random_items;
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    dec_mode = jsu_pkg::MODE_NORMAL;
    dec_hex_cnt = 2'd0;
    err_count = 0;
    burst_left = $urandom_range(1, 12);
    random_items = 0;

    add_row(8'h00, 1'b0, 1, 8'h00);
    add_row(jsu_pkg::CH_BACKSLASH, 1'b0, 0);
    add_row(jsu_pkg::CH_N, 1'b0, 1, jsu_pkg::CH_LF);
    add_row(jsu_pkg::CH_BACKSLASH, 1'b0);
    add_row(jsu_pkg::CH_T, 1'b0);
    add_row(jsu_pkg::CH_BACKSLASH, 1'b0);
    add_row(jsu_pkg::CH_R, 1'b0);
    add_row(jsu_pkg::CH_BACKSLASH, 1'b0);
    add_row(jsu_pkg::CH_B, 1'b0);
    add_row(jsu_pkg::CH_BACKSLASH, 1'b0);
    add_row(jsu_pkg::CH_F, 1'b0);
    add_row(jsu_pkg::CH_BACKSLASH, 1'b0);
    add_row(8'hFF, 1'b0, 1, 8'hFF);
    add_row(jsu_pkg::CH_BACKSLASH, 1'b0);
    add_row(jsu_pkg::CH_U, 1'b0);
    add_row("F", 1'b0);
    add_row("F", 1'b0);
    add_row("f", 1'b0);
    add_row("F", 1'b0);
    // A backslash breaks the hex run and opens a new escape; 'u' then ends it.
    add_row(jsu_pkg::CH_BACKSLASH, 1'b0);
    add_row(jsu_pkg::CH_U, 1'b0);
    add_row("7", 1'b0);
    add_row(jsu_pkg::CH_BACKSLASH, 1'b0);
    add_row(jsu_pkg::CH_U, 1'b1, 1, jsu_pkg::CH_U);
    // Short hex escape closed by a trailing backslash: five result beats.
    add_row(jsu_pkg::CH_BACKSLASH, 1'b0);
    add_row(jsu_pkg::CH_U, 1'b0);
    add_row("1", 1'b0);
    add_row("2", 1'b0);
    add_row("3", 1'b0);
    add_row(jsu_pkg::CH_BACKSLASH, 1'b1, 5, jsu_pkg::CH_U, "1", "2", "3",
            jsu_pkg::CH_BACKSLASH);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      send_beat(dir_rows[i].c, dir_rows[i].last, dir_rows[i].typed_n, dir_rows[i].chars);
    end

    while (random_items < 300) begin
      make_string(body);
      foreach (body[i]) begin
        send_beat(body[i], i == body.size() - 1, -1, '0);
        random_items++;
      end
    end
    item_valid <= 1'b0;

    while (unescaped_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver pacing: stretches of free flow, light and heavy back-pressure.
  // --------------------------------------------------------------------------
  initial begin : rx_pace
    int hold_left;
    int style;
    int beat_no;
    hold_left = 0;
    style = 0;
    beat_no = 0;
    result_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left == 0) begin
        style = $urandom_range(0, 3);
        hold_left = $urandom_range(16, 80);
      end
      hold_left--;
      beat_no++;
      case (style)
        0:       result_ready <= 1'b1;
        1:       result_ready <= ($urandom_range(0, 3) != 0);
        2:       result_ready <= (beat_no % 3 != 0);
        default: result_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: %s mismatch: got 0x%0h, expected 0x%0h", $time, what, got, want);
    err_count++;
  endtask

  jsu_pkg::out_t want_beat;

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (unescaped_q.size() == 0) begin
        report_mismatch("unexpected result beat, out_char", result.out_char, 0);
      end else begin
        want_beat = unescaped_q.pop_front();
        if (result.out_char !== want_beat.out_char)
          report_mismatch("out_char", result.out_char, want_beat.out_char);
        if (result.run_end !== want_beat.run_end)
          report_mismatch("run_end", result.run_end, want_beat.run_end);
        if (result.string_end !== want_beat.string_end)
          report_mismatch("string_end", result.string_end, want_beat.string_end);
      end
    end
  end

endmodule

// ===== json_string_unescape_top.f =====
src/jsu_pkg.sv
src/jsu_front.sv
src/jsu_queue.sv
src/jsu_back.sv
src/json_string_unescape_top.sv
src/jsu_checker.sv
dv/tb_top.sv
